FILE: src/q4dp_pkg.sv
package q4dp_pkg;

	localparam int DEF_PAIRS_PER_BLOCK = 16;

	localparam int WEIGHT_W = 8;
	localparam int ACT_W    = 16;
	localparam int SCALE_W  = 16;
	localparam int DOT_W    = 40;
	localparam int NIBBLE_W = 4;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic load_s1;   // capture an accepted item into the first stage
		logic acc_en;    // add the first-stage products into the running sum
		logic scale_en;  // load the output register with sum * scale and clear the sum
	} q4dp_cmd_t;

	// A 4-bit code c stands for c - 8, which is c with its top bit flipped.
	function automatic logic signed [NIBBLE_W:0] nibble_to_weight(
		input logic [NIBBLE_W-1:0] code
	);
		logic [NIBBLE_W-1:0] w;
		w = {~code[NIBBLE_W-1], code[NIBBLE_W-2:0]};
		return {w[NIBBLE_W-1], w};
	endfunction

endpackage

FILE: src/q4dp_ctrl.sv
module q4dp_ctrl #(
	parameter int PAIRS_PER_BLOCK = q4dp_pkg::DEF_PAIRS_PER_BLOCK
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	output logic               out_valid,
	input  logic               out_ready,
	output q4dp_pkg::q4dp_cmd_t cmd
);
	import q4dp_pkg::*;

	localparam int CNT_W = (PAIRS_PER_BLOCK > 1) ? $clog2(PAIRS_PER_BLOCK) : 1;
	localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(PAIRS_PER_BLOCK - 1);

	localparam logic [1:0] ST_IDLE  = 2'd0;
	localparam logic [1:0] ST_ACC   = 2'd1;
	localparam logic [1:0] ST_SCALE = 2'd2;

	logic [1:0]       state_q;
	logic [CNT_W-1:0] cnt_q;
	logic             last_q;
	logic             out_valid_q;
	logic             in_fire;
	logic             last_now;
	logic             out_free;

	assign in_ready  = (state_q == ST_IDLE) || ((state_q == ST_ACC) && !last_q);
	assign in_fire   = in_valid && in_ready;
	assign last_now  = (cnt_q == CNT_LAST);
	assign out_free  = !out_valid_q || out_ready;
	assign out_valid = out_valid_q;

	always_comb begin
		cmd.load_s1  = in_fire;
		cmd.acc_en   = (state_q == ST_ACC);
		cmd.scale_en = (state_q == ST_SCALE) && out_free;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			cnt_q       <= '0;
			last_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (in_fire) begin
				cnt_q  <= last_now ? '0 : cnt_q + 1'b1;
				last_q <= last_now;
			end

			if (cmd.scale_en) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end

			unique case (state_q)
				ST_IDLE: begin
					if (in_fire) begin
						state_q <= ST_ACC;
					end
				end
				ST_ACC: begin
					if (last_q) begin
						state_q <= ST_SCALE;
					end else if (!in_fire) begin
						state_q <= ST_IDLE;
					end
				end
				ST_SCALE: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

FILE: src/q4dp_datapath.sv
module q4dp_datapath #(
	parameter int PAIRS_PER_BLOCK = q4dp_pkg::DEF_PAIRS_PER_BLOCK
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  q4dp_pkg::q4dp_cmd_t                    cmd,
	input  logic        [q4dp_pkg::WEIGHT_W-1:0]   weight_byte,
	input  logic signed [q4dp_pkg::ACT_W-1:0]      act_even,
	input  logic signed [q4dp_pkg::ACT_W-1:0]      act_odd,
	input  logic signed [q4dp_pkg::SCALE_W-1:0]    block_scale,
	output logic signed [q4dp_pkg::DOT_W-1:0]      dot_value
);
	import q4dp_pkg::*;

	localparam int CNT_BITS = (PAIRS_PER_BLOCK > 1) ? $clog2(PAIRS_PER_BLOCK) : 0;
	// One item adds at most 2^19 in magnitude; the positive extreme needs one more bit.
	localparam int PROD_W = NIBBLE_W + 1 + ACT_W;
	localparam int ACC_W  = PROD_W + CNT_BITS + 1;
	localparam int SCL_W  = ACC_W + SCALE_W;

	logic        [WEIGHT_W-1:0] weight_s1;
	logic signed [ACT_W-1:0]    act_even_s1;
	logic signed [ACT_W-1:0]    act_odd_s1;
	logic signed [SCALE_W-1:0]  scale_s1;
	logic signed [ACC_W-1:0]    acc_q;
	logic signed [DOT_W-1:0]    dot_q;

	logic signed [NIBBLE_W:0]   w_lo;
	logic signed [NIBBLE_W:0]   w_hi;
	logic signed [PROD_W-1:0]   prod_lo;
	logic signed [PROD_W-1:0]   prod_hi;
	logic signed [ACC_W-1:0]    acc_next;
	logic signed [SCL_W-1:0]    scaled;

	always_comb begin
		w_lo     = nibble_to_weight(weight_s1[NIBBLE_W-1:0]);
		w_hi     = nibble_to_weight(weight_s1[WEIGHT_W-1:NIBBLE_W]);
		prod_lo  = PROD_W'(w_lo * act_even_s1);
		prod_hi  = PROD_W'(w_hi * act_odd_s1);
		acc_next = acc_q + ACC_W'(prod_lo) + ACC_W'(prod_hi);
		scaled   = SCL_W'(acc_q) * SCL_W'(scale_s1);
	end

	always_ff @(posedge clk) begin
		if (cmd.load_s1) begin
			weight_s1   <= weight_byte;
			act_even_s1 <= act_even;
			act_odd_s1  <= act_odd;
			scale_s1    <= block_scale;
		end
		if (cmd.scale_en) begin
			dot_q <= scaled[DOT_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q <= '0;
		end else if (cmd.scale_en) begin
			acc_q <= '0;
		end else if (cmd.acc_en) begin
			acc_q <= acc_next;
		end
	end

	assign dot_value = dot_q;

endmodule

FILE: src/q4_block_dot_product_top.sv
// Flow: a block's last item is accepted into the first stage, added into the running sum,
// and the sum is then scaled into the output register once that register is free.
// Throughput: one item per cycle within a block; after a block's last item, intake pauses
// for the accumulate and scale steps; scaling waits while an earlier result is not taken.
// Reset: arst_n clears the running sum, the item count and the output valid flag at once.
module q4_block_dot_product_top #(
	parameter int PAIRS_PER_BLOCK = q4dp_pkg::DEF_PAIRS_PER_BLOCK
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_ready,
	input  logic        [q4dp_pkg::WEIGHT_W-1:0] weight_byte,
	input  logic signed [q4dp_pkg::ACT_W-1:0]    act_even,
	input  logic signed [q4dp_pkg::ACT_W-1:0]    act_odd,
	input  logic signed [q4dp_pkg::SCALE_W-1:0]  block_scale,
	output logic                                out_valid,
	input  logic                                out_ready,
	output logic signed [q4dp_pkg::DOT_W-1:0]    dot_value
);
	import q4dp_pkg::*;

	// The controller counts items, decides when the running sum is complete and owns
	// the output valid flag. The datapath holds the accepted item, forms the two small
	// weight-by-activation products from it, and holds the running sum and the scaled result.
	// An item enters the first stage while the item before it is still being added,
	// unless that earlier item closes a block; then intake pauses until the sum is
	// scaled into the output register.

	q4dp_cmd_t cmd;

	q4dp_ctrl #(
		.PAIRS_PER_BLOCK(PAIRS_PER_BLOCK)
	) u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.cmd      (cmd)
	);

	// The output register is loaded only when it is empty or being taken, so a waiting
	// result holds the finished sum back and keeps intake of the next block paused.
	q4dp_datapath #(
		.PAIRS_PER_BLOCK(PAIRS_PER_BLOCK)
	) u_datapath (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.weight_byte(weight_byte),
		.act_even   (act_even),
		.act_odd    (act_odd),
		.block_scale(block_scale),
		.dot_value  (dot_value)
	);

endmodule
